### hdl/ecms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecms_pkg: shared types and constants of the edge count-min sketch
// Field widths, register codes and reset values, action codes, and the
// command and status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ecms_pkg;

   localparam int ROWS_DEF    = 2;
   localparam int BUCKETS_DEF = 32;
   localparam int MAX_ROWS    = 3;

   localparam int ID_W       = 31;
   localparam int WEIGHT_W   = 24;
   localparam int COUNT_W    = 32;
   localparam int HASH_W     = 5;
   localparam int DECAY_W    = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   // node ids are reduced modulo BUCKETS one nibble per cycle
   localparam int DIGIT_W     = 4;
   localparam int DIGITS      = 8;
   localparam int DIGIT_CNT_W = $clog2(DIGITS);

   // registers below this index are the hash multiplier and offset pairs
   localparam logic [CSR_IDX_W-1:0] CSR_DECAY_SCALE = 3'd6;

   localparam logic [HASH_W-1:0] MULT_RESET [MAX_ROWS] = '{5'd1, 5'd3, 5'd5};
   localparam logic [HASH_W-1:0] ADD_RESET  [MAX_ROWS] = '{5'd0, 5'd7, 5'd11};
   localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd32768;

   typedef enum logic [1:0] {
      ACT_INSERT = 2'd0,
      ACT_QUERY  = 2'd1,
      ACT_DECAY  = 2'd2,
      ACT_CLEAR  = 2'd3
   } action_type;

   typedef struct packed {
      logic capture;
      logic digit_step;
      logic row_read;
      logic row_update;
      logic wipe_write;
      logic decay_read;
   } ctl_cmd_type;

   typedef struct packed {
      logic pipe_busy;
   } ctl_status_type;

endpackage

### hdl/ecms_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecms_datapath: hashing, cell store and update arithmetic
// Reduces both node ids modulo BUCKETS a nibble per cycle, forms the cell
// address of each row, performs the saturating add and the running minimum,
// and streams the decay multiply through a two-stage pipeline.
// ----------------------------------------------------------------------------
module ecms_datapath #(
   parameter int ROWS    = ecms_pkg::ROWS_DEF,
   parameter int BUCKETS = ecms_pkg::BUCKETS_DEF,
   localparam int CELLS  = ROWS * BUCKETS * BUCKETS,
   localparam int ADDR_W = $clog2(CELLS),
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ecms_pkg::ctl_cmd_type           cmd,
   output ecms_pkg::ctl_status_type        status,
   input  logic [1:0]                      req_action,
   input  logic [ecms_pkg::ID_W-1:0]       req_src_node,
   input  logic [ecms_pkg::ID_W-1:0]       req_dst_node,
   input  logic [ecms_pkg::WEIGHT_W-1:0]   req_weight,
   input  logic [ROW_W-1:0]                row_sel,
   input  logic [ADDR_W-1:0]               sweep_addr,
   input  logic [ecms_pkg::HASH_W-1:0]     hash_mult [ROWS],
   input  logic [ecms_pkg::HASH_W-1:0]     hash_add  [ROWS],
   input  logic [ecms_pkg::DECAY_W-1:0]    decay_scale,
   output logic [ecms_pkg::COUNT_W-1:0]    min_total,
   output logic                            saturated
);
   import ecms_pkg::*;

   localparam int BKT_W  = $clog2(BUCKETS);
   localparam int RED_W  = BKT_W + HASH_W;
   localparam int PAD_W  = DIGITS * DIGIT_W;
   localparam int PROD_W = COUNT_W + DECAY_W;

   // x < 32 * BUCKETS; remove multiples of BUCKETS from the top down
   function automatic logic [BKT_W-1:0] reduce_mod(input logic [RED_W-1:0] x);
      logic [RED_W-1:0] v;
      v = x;
      for (int s = HASH_W - 1; s >= 0; s--) begin
         if (v >= (RED_W'(BUCKETS) << s)) begin
            v = v - (RED_W'(BUCKETS) << s);
         end
      end
      return v[BKT_W-1:0];
   endfunction

   logic [PAD_W-1:0]    src_sh_ff, dst_sh_ff;
   logic [BKT_W-1:0]    rem_src_ff, rem_dst_ff;
   logic [BKT_W-1:0]    rem_src_in, rem_dst_in;
   logic [WEIGHT_W-1:0] weight_ff;
   logic                insert_ff;
   logic [COUNT_W-1:0]  min_ff;
   logic                sat_ff;
   logic [ADDR_W-1:0]   addr_ff;
   logic [COUNT_W-1:0]  rd_data_ff;
   logic                dk_vld1_ff, dk_vld2_ff;
   logic [ADDR_W-1:0]   dk_addr1_ff, dk_addr2_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [COUNT_W-1:0]  mem [CELLS];

   logic [HASH_W-1:0]   mult_sel, add_sel;
   logic [BKT_W-1:0]    src_bkt, dst_bkt;
   logic [ADDR_W-1:0]   cell_addr;
   logic [COUNT_W:0]    sum;
   logic [COUNT_W-1:0]  upd_val;
   logic                we, re;
   logic [ADDR_W-1:0]   waddr, raddr;
   logic [COUNT_W-1:0]  wdata;

   // one modular digit step per cycle on both ids
   assign rem_src_in = reduce_mod(RED_W'({rem_src_ff, src_sh_ff[PAD_W-1 -: DIGIT_W]}));
   assign rem_dst_in = reduce_mod(RED_W'({rem_dst_ff, dst_sh_ff[PAD_W-1 -: DIGIT_W]}));

   assign mult_sel = hash_mult[row_sel];
   assign add_sel  = hash_add[row_sel];
   assign src_bkt  = reduce_mod(RED_W'(rem_src_ff) * RED_W'(mult_sel) + RED_W'(add_sel));
   assign dst_bkt  = reduce_mod(RED_W'(rem_dst_ff) * RED_W'(mult_sel) + RED_W'(add_sel));
   assign cell_addr = ADDR_W'(row_sel) * ADDR_W'(BUCKETS * BUCKETS)
                    + ADDR_W'(src_bkt) * ADDR_W'(BUCKETS) + ADDR_W'(dst_bkt);

   assign sum = {1'b0, rd_data_ff} + (COUNT_W + 1)'(weight_ff);

   always_comb begin
      if (insert_ff) begin
         upd_val = sum[COUNT_W] ? {COUNT_W{1'b1}} : sum[COUNT_W-1:0];
      end else begin
         upd_val = rd_data_ff;
      end
   end

   // single write port shared by wipe, insert and decay
   always_comb begin
      we    = 1'b0;
      waddr = sweep_addr;
      wdata = '0;
      priority if (cmd.wipe_write) begin
         we = 1'b1;
      end else if (cmd.row_update && insert_ff) begin
         we    = 1'b1;
         waddr = addr_ff;
         wdata = upd_val;
      end else if (dk_vld2_ff) begin
         we    = 1'b1;
         waddr = dk_addr2_ff;
         wdata = prod_ff[PROD_W-1:DECAY_W];
      end
   end

   assign re    = cmd.row_read | cmd.decay_read;
   assign raddr = cmd.row_read ? cell_addr : sweep_addr;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rd_data_ff <= mem[raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dk_vld1_ff <= 1'b0;
         dk_vld2_ff <= 1'b0;
      end else begin
         dk_vld1_ff <= cmd.decay_read;
         dk_vld2_ff <= dk_vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      dk_addr1_ff <= sweep_addr;
      dk_addr2_ff <= dk_addr1_ff;
      prod_ff     <= PROD_W'(rd_data_ff) * PROD_W'(decay_scale);

      if (cmd.capture) begin
         src_sh_ff  <= PAD_W'(req_src_node);
         dst_sh_ff  <= PAD_W'(req_dst_node);
         rem_src_ff <= '0;
         rem_dst_ff <= '0;
         weight_ff  <= req_weight;
         insert_ff  <= (req_action == ACT_INSERT);
         // decay and clear report a zero minimum
         min_ff     <= (req_action == ACT_INSERT || req_action == ACT_QUERY) ? '1 : '0;
         sat_ff     <= 1'b0;
      end else if (cmd.digit_step) begin
         src_sh_ff  <= src_sh_ff << DIGIT_W;
         dst_sh_ff  <= dst_sh_ff << DIGIT_W;
         rem_src_ff <= rem_src_in;
         rem_dst_ff <= rem_dst_in;
      end

      if (cmd.row_read) begin
         addr_ff <= cell_addr;
      end

      if (cmd.row_update) begin
         if (upd_val < min_ff) begin
            min_ff <= upd_val;
         end
         if (insert_ff && sum[COUNT_W]) begin
            sat_ff <= 1'b1;
         end
      end
   end

   assign status.pipe_busy = dk_vld1_ff | dk_vld2_ff;
   assign min_total        = min_ff;
   assign saturated        = sat_ff;

endmodule

### hdl/ecms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecms_ctrl: sequencing of the edge count-min sketch
// Runs the reset clearing pass, the id reduction steps, the read and update
// of each row, the decay and clear sweeps, and strobes the result.
// ----------------------------------------------------------------------------
module ecms_ctrl #(
   parameter int ROWS    = ecms_pkg::ROWS_DEF,
   parameter int BUCKETS = ecms_pkg::BUCKETS_DEF,
   localparam int CELLS  = ROWS * BUCKETS * BUCKETS,
   localparam int ADDR_W = $clog2(CELLS),
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   input  logic [1:0]                req_action,
   output logic                      busy,
   output logic                      rsp_valid,
   output ecms_pkg::ctl_cmd_type     cmd,
   input  ecms_pkg::ctl_status_type  status,
   output logic [ROW_W-1:0]          row_sel,
   output logic [ADDR_W-1:0]         sweep_addr
);
   import ecms_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_HASH,
      ST_ROW_RD,
      ST_ROW_UPD,
      ST_DECAY,
      ST_DRAIN,
      ST_WIPE
   } state_type;

   state_type              state_ff, state_in;
   logic [DIGIT_CNT_W-1:0] digit_ff, digit_in;
   logic [ROW_W-1:0]       row_ff, row_in;
   logic [ADDR_W-1:0]      sweep_ff, sweep_in;
   logic                   busy_ff, rsp_valid_ff, rsp_in;
   logic                   sweep_last;

   assign sweep_last = (sweep_ff == ADDR_W'(CELLS - 1));

   always_comb begin
      state_in = state_ff;
      digit_in = digit_ff;
      row_in   = row_ff;
      sweep_in = sweep_ff;
      rsp_in   = 1'b0;
      unique case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               sweep_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_start) begin
               digit_in = '0;
               row_in   = '0;
               sweep_in = '0;
               unique case (action_type'(req_action))
                  ACT_INSERT, ACT_QUERY: state_in = ST_HASH;
                  ACT_DECAY:             state_in = ST_DECAY;
                  ACT_CLEAR:             state_in = ST_WIPE;
               endcase
            end
         end
         ST_HASH: begin
            digit_in = digit_ff + 1'b1;
            if (digit_ff == DIGIT_CNT_W'(DIGITS - 1)) begin
               state_in = ST_ROW_RD;
            end
         end
         ST_ROW_RD: begin
            state_in = ST_ROW_UPD;
         end
         ST_ROW_UPD: begin
            if (row_ff == ROW_W'(ROWS - 1)) begin
               rsp_in   = 1'b1;
               state_in = ST_IDLE;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = ST_ROW_RD;
            end
         end
         ST_DECAY: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               sweep_in = '0;
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // wait for the last product to be written back
            if (!status.pipe_busy) begin
               rsp_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_WIPE: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               sweep_in = '0;
               rsp_in   = 1'b1;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         digit_ff     <= '0;
         row_ff       <= '0;
         sweep_ff     <= '0;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         digit_ff     <= digit_in;
         row_ff       <= row_in;
         sweep_ff     <= sweep_in;
         busy_ff      <= (state_in != ST_IDLE);
         rsp_valid_ff <= rsp_in;
      end
   end

   assign cmd.capture    = (state_ff == ST_IDLE) && req_start;
   assign cmd.digit_step = (state_ff == ST_HASH);
   assign cmd.row_read   = (state_ff == ST_ROW_RD);
   assign cmd.row_update = (state_ff == ST_ROW_UPD);
   assign cmd.wipe_write = (state_ff == ST_INIT) || (state_ff == ST_WIPE);
   assign cmd.decay_read = (state_ff == ST_DECAY);

   assign busy       = busy_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign row_sel    = row_ff;
   assign sweep_addr = sweep_ff;

   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe lasted more than one cycle");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !busy_ff)
      else $error("result strobed while still busy");

   a_upd_after_rd: assert property (@(posedge clock) disable iff (reset)
      cmd.row_update |-> $past(cmd.row_read))
      else $error("row update without a preceding read");

   a_reset_busy: assert property (@(posedge clock)
      reset |=> (busy_ff && !rsp_valid_ff))
      else $error("block not busy with the clearing pass after reset");

endmodule

### hdl/edge_count_min_sketch.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_count_min_sketch: count-min sketch over graph edges
// Holds ROWS matrices of BUCKETS x BUCKETS Q24.8 counts; supports insert,
// query, decay and clear of the whole store.
//
// Usage: a command is taken at a clock edge with req_start high and busy low.
// Insert and query first reduce both node ids modulo BUCKETS a nibble at a
// time, then each row does a read and a write-back on the cell memory. Decay
// streams every cell through a 32x16 multiply. Clear writes zero to one cell
// per cycle. busy drops in the cycle the result is strobed on rsp_valid for
// one cycle; a new command may start in that same cycle. The receiver cannot
// stall: each transfer is taken as it is shown. After reset the block clears
// the store with busy high and gives no result. Registers are written on the
// csr channel, always ready; the user must write them only while the block is
// idle, which the block itself does not enforce. An index beyond the last
// register is dropped.
// ----------------------------------------------------------------------------
module edge_count_min_sketch #(
   parameter int ROWS    = ecms_pkg::ROWS_DEF,
   parameter int BUCKETS = ecms_pkg::BUCKETS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_start,
   output logic                              busy,
   input  logic [1:0]                        req_action,
   input  logic [ecms_pkg::ID_W-1:0]         req_src_node,
   input  logic [ecms_pkg::ID_W-1:0]         req_dst_node,
   input  logic [ecms_pkg::WEIGHT_W-1:0]     req_weight,
   output logic                              rsp_valid,
   output logic [ecms_pkg::COUNT_W-1:0]      rsp_min_total,
   output logic                              rsp_saturated,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [ecms_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ecms_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import ecms_pkg::*;

   localparam int CELLS  = ROWS * BUCKETS * BUCKETS;
   localparam int ADDR_W = $clog2(CELLS);
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;

   logic [HASH_W-1:0]  mult_ff [ROWS];
   logic [HASH_W-1:0]  add_ff  [ROWS];
   logic [DECAY_W-1:0] decay_ff;

   ctl_cmd_type        cmd;
   ctl_status_type     status;
   logic [ROW_W-1:0]   row_sel;
   logic [ADDR_W-1:0]  sweep_addr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROWS; r++) begin
            mult_ff[r] <= MULT_RESET[r];
            add_ff[r]  <= ADD_RESET[r];
         end
         decay_ff <= DECAY_RESET;
      end else if (csr_valid && csr_ready) begin
         // hash registers come in multiplier/offset pairs, one pair per row
         for (int r = 0; r < ROWS; r++) begin
            if (csr_index < CSR_DECAY_SCALE &&
                csr_index[CSR_IDX_W-1:1] == (CSR_IDX_W - 1)'(r)) begin
               if (csr_index[0]) begin
                  add_ff[r] <= csr_wdata[HASH_W-1:0];
               end else begin
                  mult_ff[r] <= csr_wdata[HASH_W-1:0];
               end
            end
         end
         if (csr_index == CSR_DECAY_SCALE) begin
            decay_ff <= csr_wdata[DECAY_W-1:0];
         end
      end
   end

   ecms_ctrl #(
      .ROWS    (ROWS),
      .BUCKETS (BUCKETS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_start  (req_start),
      .req_action (req_action),
      .busy       (busy),
      .rsp_valid  (rsp_valid),
      .cmd        (cmd),
      .status     (status),
      .row_sel    (row_sel),
      .sweep_addr (sweep_addr)
   );

   ecms_datapath #(
      .ROWS    (ROWS),
      .BUCKETS (BUCKETS)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_action   (req_action),
      .req_src_node (req_src_node),
      .req_dst_node (req_dst_node),
      .req_weight   (req_weight),
      .row_sel      (row_sel),
      .sweep_addr   (sweep_addr),
      .hash_mult    (mult_ff),
      .hash_add     (add_ff),
      .decay_scale  (decay_ff),
      .min_total    (rsp_min_total),
      .saturated    (rsp_saturated)
   );

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench of the edge count-min sketch
// Drives insert, query, decay and clear commands and csr writes into the
// block. A scoreboard keeps its own copy of the cell store and the hash and
// decay settings, predicts the result of every accepted command and checks
// each strobed result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
   import ecms_pkg::*;

   localparam int ROWS    = ROWS_DEF;
   localparam int BUCKETS = BUCKETS_DEF;
   localparam int CELLS   = ROWS * BUCKETS * BUCKETS;
   localparam int STALL_LIMIT = 10000;

   localparam logic [CSR_IDX_W-1:0] CSR_HASH_MULT_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_ADD_0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_MULT_1 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_ADD_1  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_MULT_2 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HASH_ADD_2  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED    = 3'd7;

   localparam logic [ID_W-1:0]     ID_MAX     = {ID_W{1'b1}};
   localparam logic [WEIGHT_W-1:0] WEIGHT_MAX = {WEIGHT_W{1'b1}};

   typedef struct {
      logic [COUNT_W-1:0] min_total;
      logic               saturated;
   } sketch_result_type;

   class edge_sketch_tracker;
      logic [COUNT_W-1:0] cells [CELLS];
      logic [HASH_W-1:0]  hash_mult [MAX_ROWS];
      logic [HASH_W-1:0]  hash_add [MAX_ROWS];
      logic [DECAY_W-1:0] decay_scale;
      sketch_result_type  expected_counts [$];
      int unsigned        fail_count;

      function new();
         foreach (cells[k]) cells[k] = '0;
         for (int r = 0; r < MAX_ROWS; r++) begin
            hash_mult[r] = MULT_RESET[r];
            hash_add[r]  = ADD_RESET[r];
         end
         decay_scale = DECAY_RESET;
         fail_count  = 0;
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         if (idx < CSR_DECAY_SCALE) begin
            // even index: multiplier, odd index: offset of row idx/2
            if (idx[0] == 1'b0)
               hash_mult[idx >> 1] = data[HASH_W-1:0];
            else
               hash_add[idx >> 1] = data[HASH_W-1:0];
         end else if (idx == CSR_DECAY_SCALE) begin
            decay_scale = data[DECAY_W-1:0];
         end
      endfunction

      function int unsigned hash_bucket(logic [ID_W-1:0] id, int row);
         logic [63:0] mixed;
         mixed = 64'(id) * 64'(hash_mult[row]) + 64'(hash_add[row]);
         return int'(mixed % BUCKETS);
      endfunction

      function int unsigned cell_slot(int row, logic [ID_W-1:0] src, logic [ID_W-1:0] dst);
         return (row * BUCKETS + hash_bucket(src, row)) * BUCKETS + hash_bucket(dst, row);
      endfunction

      function void note_command(action_type act, logic [ID_W-1:0] src,
                                 logic [ID_W-1:0] dst, logic [WEIGHT_W-1:0] wt);
         sketch_result_type want;
         logic [COUNT_W:0]  sum;
         int unsigned       slot;
         want.min_total = '0;
         want.saturated = 1'b0;
         case (act)
            ACT_INSERT, ACT_QUERY: begin
               want.min_total = '1;
               for (int r = 0; r < ROWS; r++) begin
                  slot = cell_slot(r, src, dst);
                  if (act == ACT_INSERT) begin
                     sum = {1'b0, cells[slot]} + wt;
                     if (sum[COUNT_W]) begin
                        cells[slot]    = '1;
                        want.saturated = 1'b1;
                     end else begin
                        cells[slot] = sum[COUNT_W-1:0];
                     end
                  end
                  if (cells[slot] < want.min_total) want.min_total = cells[slot];
               end
            end
            ACT_DECAY: begin
               foreach (cells[k]) cells[k] = COUNT_W'((64'(cells[k]) * decay_scale) >> 16);
            end
            default: begin
               foreach (cells[k]) cells[k] = '0;
            end
         endcase
         expected_counts = {expected_counts, want};
      endfunction

      function void check_result(logic [COUNT_W-1:0] min_total, logic saturated);
         sketch_result_type want;
         if (expected_counts.size() == 0) begin
            $display("%0t: unexpected result minimum=%h saturated=%b",
                     $time, min_total, saturated);
            fail_count++;
            return;
         end
         want = expected_counts.pop_front();
         if (min_total !== want.min_total) begin
            $display("%0t: minimum mismatch: expected %h, actual %h",
                     $time, want.min_total, min_total);
            fail_count++;
         end
         if (saturated !== want.saturated) begin
            $display("%0t: saturated mismatch: expected %b, actual %b",
                     $time, want.saturated, saturated);
            fail_count++;
         end
      endfunction
   endclass

   logic                  clock;
   logic                  reset;
   logic                  req_start;
   logic                  busy;
   logic [1:0]            req_action;
   logic [ID_W-1:0]       req_src_node;
   logic [ID_W-1:0]       req_dst_node;
   logic [WEIGHT_W-1:0]   req_weight;
   logic                  rsp_valid;
   logic [COUNT_W-1:0]    rsp_min_total;
   logic                  rsp_saturated;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   edge_sketch_tracker tracker;
   bit                 idle_enabled;

   edge_count_min_sketch #(
      .ROWS    (ROWS),
      .BUCKETS (BUCKETS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_start     (req_start),
      .busy          (busy),
      .req_action    (req_action),
      .req_src_node  (req_src_node),
      .req_dst_node  (req_dst_node),
      .req_weight    (req_weight),
      .rsp_valid     (rsp_valid),
      .rsp_min_total (rsp_min_total),
      .rsp_saturated (rsp_saturated),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // check the result of the previous command before noting a new one
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid) tracker.check_result(rsp_min_total, rsp_saturated);
         if (req_start && !busy)
            tracker.note_command(action_type'(req_action), req_src_node,
                                 req_dst_node, req_weight);
      end
   end

   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_start && !busy) || rsp_valid || (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Some tests failed");
      $finish;
   end

   // every task starts and ends at a falling edge
   task automatic send_cmd(action_type act, logic [ID_W-1:0] src,
                           logic [ID_W-1:0] dst, logic [WEIGHT_W-1:0] wt);
      if (idle_enabled && $urandom_range(99) < 16) begin
         req_start = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
      req_start    = 1'b1;
      req_action   = act;
      req_src_node = src;
      req_dst_node = dst;
      req_weight   = wt;
      do @(posedge clock); while (busy);
      @(negedge clock);
      req_start = 1'b0;
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      do @(posedge clock); while (!csr_ready);
      tracker.write_reg(idx, data);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain_results();
      while (tracker.expected_counts.size() != 0) @(negedge clock);
   endtask

   task automatic load_config(logic [CSR_DATA_W-1:0] m0, logic [CSR_DATA_W-1:0] a0,
                              logic [CSR_DATA_W-1:0] m1, logic [CSR_DATA_W-1:0] a1,
                              logic [CSR_DATA_W-1:0] m2, logic [CSR_DATA_W-1:0] a2,
                              logic [CSR_DATA_W-1:0] scale);
      drain_results();
      write_csr(CSR_HASH_MULT_0, m0);
      write_csr(CSR_HASH_ADD_0, a0);
      write_csr(CSR_HASH_MULT_1, m1);
      write_csr(CSR_HASH_ADD_1, a1);
      write_csr(CSR_HASH_MULT_2, m2);
      write_csr(CSR_HASH_ADD_2, a2);
      write_csr(CSR_DECAY_SCALE, scale);
      // unmapped index: the block must drop it
      write_csr(CSR_UNMAPPED, CSR_DATA_W'($urandom));
   endtask

   function automatic logic [ID_W-1:0] pick_node();
      case ($urandom_range(9))
         0, 1, 2: return ID_W'($urandom);
         3:       return ID_MAX;
         default: return ID_W'($urandom_range(15));
      endcase
   endfunction

   function automatic logic [WEIGHT_W-1:0] pick_weight();
      case ($urandom_range(9))
         0:             return WEIGHT_MAX;
         1:             return '0;
         2, 3, 4, 5:    return WEIGHT_W'($urandom);
         default:       return WEIGHT_W'($urandom_range(255));
      endcase
   endfunction

   task automatic hammer_edge(logic [ID_W-1:0] src, logic [ID_W-1:0] dst, int unsigned reps);
      for (int unsigned i = 0; i < reps; i++) begin
         send_cmd(ACT_INSERT, src, dst, WEIGHT_MAX);
         if (i % 32 == 31) send_cmd(ACT_QUERY, src, dst, '0);
      end
   endtask

   task automatic run_random(int unsigned count);
      int unsigned roll;
      for (int unsigned i = 0; i < count; i++) begin
         // hold off once per phase until the block has answered everything
         if (i == count / 2) drain_results();
         roll = $urandom_range(99);
         if (roll < 2)
            send_cmd(ACT_DECAY, pick_node(), pick_node(), pick_weight());
         else if (roll < 4)
            send_cmd(ACT_CLEAR, pick_node(), pick_node(), pick_weight());
         else if (roll < 52)
            send_cmd(ACT_INSERT, pick_node(), pick_node(), pick_weight());
         else
            send_cmd(ACT_QUERY, pick_node(), pick_node(), pick_weight());
      end
   endtask

   initial begin
      tracker      = new();
      idle_enabled = 1'b1;
      reset        = 1'b1;
      req_start    = 1'b0;
      req_action   = ACT_INSERT;
      req_src_node = '0;
      req_dst_node = '0;
      req_weight   = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_wdata    = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      // wait out the store wipe that follows reset
      @(negedge clock);
      while (busy) @(negedge clock);

      // directed commands with the reset settings
      send_cmd(ACT_QUERY, '0, '0, '0);
      send_cmd(ACT_INSERT, '0, '0, WEIGHT_MAX);
      send_cmd(ACT_INSERT, ID_MAX, ID_MAX, '0);
      send_cmd(ACT_INSERT, ID_MAX, '0, 24'd1);
      send_cmd(ACT_QUERY, '0, '0, WEIGHT_MAX);
      send_cmd(ACT_QUERY, ID_MAX, ID_MAX, '0);
      send_cmd(ACT_INSERT, 31'h5555_5555, 31'h2AAA_AAAA, 24'hAA_AAAA);
      send_cmd(ACT_INSERT, 31'h2AAA_AAAA, 31'h5555_5555, 24'h55_5555);
      send_cmd(ACT_QUERY, 31'h5555_5555, 31'h2AAA_AAAA, '0);
      // lands on the same cells as edge (0, 0) in both rows
      send_cmd(ACT_INSERT, 31'd32, 31'd32, 24'h00_0100);
      send_cmd(ACT_QUERY, '0, '0, '0);
      send_cmd(ACT_DECAY, '0, '0, '0);
      send_cmd(ACT_QUERY, '0, '0, '0);
      send_cmd(ACT_CLEAR, ID_MAX, ID_MAX, WEIGHT_MAX);
      send_cmd(ACT_QUERY, '0, '0, '0);

      // zero and top multipliers, extreme offsets, full decay factor; upper data bits set
      load_config(16'hFFE0, 16'h001F, 16'h001F, 16'hFFE0, 16'hFFE0, 16'hFFFF, 16'hFFFF);
      send_cmd(ACT_INSERT, 31'd1, 31'd2, WEIGHT_MAX);
      send_cmd(ACT_INSERT, 31'd100, 31'd200, 24'h80_0000);
      send_cmd(ACT_QUERY, 31'd7, 31'd9, '0);
      send_cmd(ACT_DECAY, '0, '0, '0);
      send_cmd(ACT_QUERY, 31'd1, 31'd2, '0);

      // drive one edge past the count limit, then decay with factor zero
      load_config(16'd1, 16'd0, 16'd1, 16'd0, 16'd1, 16'd0, 16'd0);
      hammer_edge(31'd3, 31'd4, 280);
      send_cmd(ACT_INSERT, 31'd3, 31'd4, '0);
      send_cmd(ACT_QUERY, 31'd3, 31'd4, '0);
      send_cmd(ACT_DECAY, '0, '0, '0);
      send_cmd(ACT_QUERY, 31'd3, 31'd4, '0);

      run_random(230);

      // top settings and no idling on the sender
      load_config(16'd31, 16'd31, 16'd31, 16'd31, 16'd31, 16'd31, 16'hFFFF);
      idle_enabled = 1'b0;
      run_random(230);
      idle_enabled = 1'b1;

      for (int p = 0; p < 3; p++) begin
         load_config(CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                     CSR_DATA_W'($urandom), CSR_DATA_W'($urandom), CSR_DATA_W'($urandom),
                     CSR_DATA_W'($urandom));
         run_random(230);
      end

      drain_results();
      repeat (32) @(posedge clock);
      if (tracker.fail_count == 0 && tracker.expected_counts.size() == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
